// File: rtl/sbcr_pkg.sv
// ----------------------------------------------------------------------------
// Serial bus command receiver package
// Shared types, codes and constants for the command receiver.
// ----------------------------------------------------------------------------
package sbcr_pkg;

    localparam logic [7:0] DEV_NONE      = 8'hFF;
    localparam logic [7:0] UNLISTEN_BYTE = 8'h3F;
    localparam logic [7:0] UNTALK_BYTE   = 8'h5F;
    localparam logic [7:0] GROUP_MASK    = 8'hE0;
    localparam logic [7:0] LISTEN_GROUP  = 8'h20;
    localparam logic [7:0] TALK_GROUP    = 8'h40;
    localparam logic [7:0] TOP_MASK      = 8'hF0;
    localparam logic [7:0] SEC_TOP_A     = 8'h60;
    localparam logic [7:0] SEC_TOP_B     = 8'hC0;
    localparam logic [7:0] SEC_TOP_C     = 8'hF0;
    localparam logic [7:0] CLOSE_TOP     = 8'hE0;

    localparam logic CMD_CLOCK = 1'b0;
    localparam logic CMD_ATN   = 1'b1;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_LISTEN    = 3'd1,
        ACT_TALK      = 3'd2,
        ACT_SECONDARY = 3'd3,
        ACT_UNLISTEN  = 3'd4,
        ACT_UNTALK    = 3'd5
    } sbcr_action_t;

    typedef struct packed {
        logic command;
        logic line_level;
        logic data_line_high;
        logic clk_line_high;
    } sbcr_event_t;

    typedef struct packed {
        logic       clk_prev;
        logic       atn_low_now;
        logic       atn_prev;
        logic       handshake_pending;
        logic       handshake_just_cleared;
        logic [7:0] shift_bits;
        logic [3:0] bit_count;
        logic [7:0] device;
        logic [7:0] secondary;
        logic       listening;
        logic       talking;
    } sbcr_state_t;

    typedef struct packed {
        sbcr_action_t kind;
        logic [4:0]   device;
        logic [3:0]   secondary;
    } sbcr_act_t;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [4:0] action_device;
        logic [3:0] action_secondary;
        logic       byte_done;
        logic [7:0] command_byte;
        logic       host_listening;
        logic       host_talking;
        logic [7:0] device_now;
        logic [7:0] secondary_now;
        logic       atn_asserted;
    } sbcr_result_t;

endpackage

// File: rtl/sbcr_if.sv
// ----------------------------------------------------------------------------
// Serial bus command receiver channels
// Valid/ready channels for line events and for decoded results.
// ----------------------------------------------------------------------------
interface sbcr_event_if;
    logic valid;
    logic ready;
    logic command;
    logic line_level;
    logic data_line_high;
    logic clk_line_high;

    modport source (
        output valid, command, line_level, data_line_high, clk_line_high,
        input  ready
    );
    modport sink (
        input  valid, command, line_level, data_line_high, clk_line_high,
        output ready
    );
endinterface

interface sbcr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [4:0] action_device;
    logic [3:0] action_secondary;
    logic       byte_done;
    logic [7:0] command_byte;
    logic       host_listening;
    logic       host_talking;
    logic [7:0] device_now;
    logic [7:0] secondary_now;
    logic       atn_asserted;

    modport source (
        output valid, bus_action, action_device, action_secondary, byte_done,
               command_byte, host_listening, host_talking, device_now,
               secondary_now, atn_asserted,
        input  ready
    );
    modport sink (
        input  valid, bus_action, action_device, action_secondary, byte_done,
               command_byte, host_listening, host_talking, device_now,
               secondary_now, atn_asserted,
        output ready
    );
endinterface

// File: rtl/serial_bus_command_receiver_top.sv
// An accepted event is registered at the input, then its result in the result register.
// Throughput: one event per cycle while results are taken; the event step is one pass of logic.
// A stalled result register holds, and the input register then holds one more event.
// Reset: rst_n clears the session to no device, no secondary, flags low, decoding off.
// ----------------------------------------------------------------------------
// Serial bus command receiver top level
// Registers line events, steps the session state and holds each result.
// ----------------------------------------------------------------------------
module serial_bus_command_receiver_top
    import sbcr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_enable,
    input  logic          cfg_write_data,
    sbcr_event_if.sink    event_ch,
    sbcr_result_if.source result_ch
);

    logic         protocol_enable_reg;
    logic         in_valid_reg;
    sbcr_event_t  in_event_reg;
    logic         out_valid_reg;
    sbcr_result_t out_result_reg;
    sbcr_state_t  state_reg;
    sbcr_state_t  state_next;
    sbcr_result_t result_next;
    logic         advance;

    localparam sbcr_state_t STATE_RESET = '{
        clk_prev: 1'b0, atn_low_now: 1'b0, atn_prev: 1'b0,
        handshake_pending: 1'b0, handshake_just_cleared: 1'b0,
        shift_bits: 8'd0, bit_count: 4'd0, device: DEV_NONE,
        secondary: DEV_NONE, listening: 1'b0, talking: 1'b0
    };

    assign advance        = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign event_ch.ready = !in_valid_reg || advance;

    sbcr_step u_step (
        .protocol_enable (protocol_enable_reg),
        .ev              (in_event_reg),
        .state_cur       (state_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_enable_reg <= 1'b0;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            state_reg           <= STATE_RESET;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                protocol_enable_reg <= cfg_write_data;
            end
            if (event_ch.ready)
            begin
                in_valid_reg <= event_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_ch.valid && event_ch.ready)
        begin
            in_event_reg.command        <= event_ch.command;
            in_event_reg.line_level     <= event_ch.line_level;
            in_event_reg.data_line_high <= event_ch.data_line_high;
            in_event_reg.clk_line_high  <= event_ch.clk_line_high;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.bus_action       = out_result_reg.bus_action;
    assign result_ch.action_device    = out_result_reg.action_device;
    assign result_ch.action_secondary = out_result_reg.action_secondary;
    assign result_ch.byte_done        = out_result_reg.byte_done;
    assign result_ch.command_byte     = out_result_reg.command_byte;
    assign result_ch.host_listening   = out_result_reg.host_listening;
    assign result_ch.host_talking     = out_result_reg.host_talking;
    assign result_ch.device_now       = out_result_reg.device_now;
    assign result_ch.secondary_now    = out_result_reg.secondary_now;
    assign result_ch.atn_asserted     = out_result_reg.atn_asserted;

`ifndef SYNTH
    a_action_has_device: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.bus_action != ACT_NONE
        |-> out_result_reg.device_now != DEV_NONE)
        else $error("bus action reported with no device set");

    a_byte_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.byte_done
        |-> out_result_reg.command_byte == 8'd0 && out_result_reg.bus_action == ACT_NONE)
        else $error("command byte or action without a completed byte");

    a_stalled_event_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_event_reg))
        else $error("stalled event lost");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.bit_count[3])
        else $error("bit count left the byte range");
`endif

endmodule

// File: rtl/sbcr_decode.sv
// ----------------------------------------------------------------------------
// Command byte decoder
// Turns a completed attention byte into session updates and a bus action.
// ----------------------------------------------------------------------------
module sbcr_decode
    import sbcr_pkg::*;
(
    input  logic [7:0]  cmd_byte,
    input  sbcr_state_t state_cur,
    output sbcr_state_t state_upd,
    output sbcr_act_t   act
);

    logic [7:0] top_bits;
    logic       has_device;

    assign top_bits   = cmd_byte & TOP_MASK;
    assign has_device = (state_cur.device != DEV_NONE);

    always_comb
    begin
        state_upd = state_cur;
        act       = '{kind: ACT_NONE, device: 5'd0, secondary: 4'd0};
        if (cmd_byte == UNLISTEN_BYTE)
        begin
            state_upd.listening = 1'b0;
            if (has_device)
            begin
                act.kind   = ACT_UNLISTEN;
                act.device = state_cur.device[4:0];
            end
        end
        else if (cmd_byte == UNTALK_BYTE)
        begin
            state_upd.talking = 1'b0;
            if (has_device)
            begin
                act.kind   = ACT_UNTALK;
                act.device = state_cur.device[4:0];
            end
        end
        else if ((cmd_byte & GROUP_MASK) == LISTEN_GROUP)
        begin
            state_upd.device    = {3'd0, cmd_byte[4:0]};
            state_upd.listening = 1'b0;
            state_upd.talking   = 1'b1;
            state_upd.secondary = DEV_NONE;
            act.kind            = ACT_LISTEN;
            act.device          = cmd_byte[4:0];
        end
        else if ((cmd_byte & GROUP_MASK) == TALK_GROUP)
        begin
            state_upd.device    = {3'd0, cmd_byte[4:0]};
            state_upd.talking   = 1'b0;
            state_upd.listening = 1'b1;
            state_upd.secondary = DEV_NONE;
            act.kind            = ACT_TALK;
            act.device          = cmd_byte[4:0];
        end
        else if (top_bits == SEC_TOP_A || top_bits == SEC_TOP_B || top_bits == SEC_TOP_C)
        begin
            state_upd.secondary = {4'd0, cmd_byte[3:0]};
            if (has_device)
            begin
                act.kind      = ACT_SECONDARY;
                act.device    = state_cur.device[4:0];
                act.secondary = cmd_byte[3:0];
            end
        end
        else if (top_bits == CLOSE_TOP)
        begin
            state_upd.secondary = {4'd0, cmd_byte[3:0]};
        end
    end

endmodule

// File: rtl/sbcr_step.sv
// ----------------------------------------------------------------------------
// Line event step
// Applies one clock or ATN event to the session state and forms the result.
// ----------------------------------------------------------------------------
module sbcr_step
    import sbcr_pkg::*;
(
    input  logic         protocol_enable,
    input  sbcr_event_t  ev,
    input  sbcr_state_t  state_cur,
    output sbcr_state_t  state_next,
    output sbcr_result_t result
);

    logic [7:0]  shifted;
    logic [3:0]  count_inc;
    sbcr_state_t dec_state;
    sbcr_act_t   dec_act;
    sbcr_act_t   act;
    logic        done;
    logic        clk_fall;
    logic        clk_rise;
    logic        atn_fall;

    assign shifted   = state_cur.shift_bits
                     | ({7'd0, ev.data_line_high} << state_cur.bit_count[2:0]);
    assign count_inc = state_cur.bit_count + 4'd1;
    assign clk_fall  = state_cur.clk_prev & ~ev.line_level;
    assign clk_rise  = ~state_cur.clk_prev & ev.line_level;
    assign atn_fall  = ~state_cur.atn_prev & ev.line_level;

    sbcr_decode u_decode (
        .cmd_byte  (shifted),
        .state_cur (state_cur),
        .state_upd (dec_state),
        .act       (dec_act)
    );

    always_comb
    begin
        state_next = state_cur;
        act        = '{kind: ACT_NONE, device: 5'd0, secondary: 4'd0};
        done       = 1'b0;
        if (ev.command == CMD_CLOCK)
        begin
            state_next.clk_prev = ev.line_level;
            if (protocol_enable && state_cur.atn_low_now)
            begin
                if (state_cur.handshake_pending && clk_rise)
                begin
                    state_next.handshake_pending      = 1'b0;
                    state_next.handshake_just_cleared = 1'b1;
                end
                else if (!state_cur.handshake_pending && clk_fall)
                begin
                    if (state_cur.handshake_just_cleared)
                    begin
                        state_next.handshake_just_cleared = 1'b0;
                    end
                    else if (count_inc[3])
                    begin
                        done                 = 1'b1;
                        act                  = dec_act;
                        state_next.device    = dec_state.device;
                        state_next.secondary = dec_state.secondary;
                        state_next.listening = dec_state.listening;
                        state_next.talking   = dec_state.talking;
                        state_next.shift_bits = 8'd0;
                        state_next.bit_count  = 4'd0;
                    end
                    else
                    begin
                        state_next.shift_bits = shifted;
                        state_next.bit_count  = count_inc;
                    end
                end
            end
        end
        else
        begin
            state_next.atn_low_now = ev.line_level;
            state_next.atn_prev    = ev.line_level;
            if (protocol_enable)
            begin
                if (atn_fall)
                begin
                    state_next.secondary              = DEV_NONE;
                    state_next.listening              = 1'b0;
                    state_next.talking                = 1'b0;
                    state_next.handshake_pending      = 1'b1;
                    state_next.handshake_just_cleared = 1'b0;
                    state_next.shift_bits             = 8'd0;
                    state_next.bit_count              = 4'd0;
                    state_next.clk_prev               = ev.clk_line_high;
                end
                else if (!ev.line_level)
                begin
                    state_next.handshake_pending      = 1'b0;
                    state_next.handshake_just_cleared = 1'b0;
                    state_next.shift_bits             = 8'd0;
                    state_next.bit_count              = 4'd0;
                end
            end
        end
    end

    always_comb
    begin
        result.bus_action       = act.kind;
        result.action_device    = act.device;
        result.action_secondary = act.secondary;
        result.byte_done        = done;
        result.command_byte     = done ? shifted : 8'd0;
        result.host_listening   = state_next.listening;
        result.host_talking     = state_next.talking;
        result.device_now       = state_next.device;
        result.secondary_now    = state_next.secondary;
        result.atn_asserted     = state_next.atn_low_now;
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Serial bus command receiver testbench
// Drives clock-line and ATN-line events through the event channel and checks
// every decoded result against a cycle-free model of the receiver session.
// Directed attention sequences come first, then random sessions with noise,
// under changing idle patterns on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
    import sbcr_pkg::*;

    class command_session_scoreboard;
        sbcr_state_t  session;
        bit           decode_on;
        sbcr_result_t expected_results[$];
        int           mismatches;

        function new();
            session           = '0;
            session.device    = DEV_NONE;
            session.secondary = DEV_NONE;
            decode_on         = 1'b0;
            mismatches        = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        function void note_event(sbcr_event_t e);
            sbcr_result_t r;
            logic         falling;
            logic         rising;
            logic [7:0]   b;
            logic [7:0]   top;
            r = '0;
            if (e.command == CMD_CLOCK)
            begin
                falling = session.clk_prev && !e.line_level;
                rising  = !session.clk_prev && e.line_level;
                session.clk_prev = e.line_level;
                if (decode_on && session.atn_low_now)
                begin
                    if (session.handshake_pending && rising)
                    begin
                        session.handshake_pending      = 1'b0;
                        session.handshake_just_cleared = 1'b1;
                    end
                    else if (!session.handshake_pending && falling)
                    begin
                        if (session.handshake_just_cleared)
                        begin
                            session.handshake_just_cleared = 1'b0;
                        end
                        else
                        begin
                            if (e.data_line_high)
                                session.shift_bits[session.bit_count[2:0]] = 1'b1;
                            session.bit_count = session.bit_count + 4'd1;
                            if (session.bit_count >= 4'd8)
                            begin
                                b   = session.shift_bits;
                                top = b & TOP_MASK;
                                r.byte_done    = 1'b1;
                                r.command_byte = b;
                                session.shift_bits = '0;
                                session.bit_count  = '0;
                                if (b == UNLISTEN_BYTE)
                                begin
                                    session.listening = 1'b0;
                                    if (session.device != DEV_NONE)
                                    begin
                                        r.bus_action    = ACT_UNLISTEN;
                                        r.action_device = session.device[4:0];
                                    end
                                end
                                else if (b == UNTALK_BYTE)
                                begin
                                    session.talking = 1'b0;
                                    if (session.device != DEV_NONE)
                                    begin
                                        r.bus_action    = ACT_UNTALK;
                                        r.action_device = session.device[4:0];
                                    end
                                end
                                else if ((b & GROUP_MASK) == LISTEN_GROUP)
                                begin
                                    session.device    = {3'b000, b[4:0]};
                                    session.listening = 1'b0;
                                    session.talking   = 1'b1;
                                    session.secondary = DEV_NONE;
                                    r.bus_action      = ACT_LISTEN;
                                    r.action_device   = b[4:0];
                                end
                                else if ((b & GROUP_MASK) == TALK_GROUP)
                                begin
                                    session.device    = {3'b000, b[4:0]};
                                    session.talking   = 1'b0;
                                    session.listening = 1'b1;
                                    session.secondary = DEV_NONE;
                                    r.bus_action      = ACT_TALK;
                                    r.action_device   = b[4:0];
                                end
                                else if (top == SEC_TOP_A || top == SEC_TOP_B ||
                                         top == SEC_TOP_C)
                                begin
                                    session.secondary = {4'h0, b[3:0]};
                                    if (session.device != DEV_NONE)
                                    begin
                                        r.bus_action       = ACT_SECONDARY;
                                        r.action_device    = session.device[4:0];
                                        r.action_secondary = b[3:0];
                                    end
                                end
                                else if (top == CLOSE_TOP)
                                begin
                                    session.secondary = {4'h0, b[3:0]};
                                end
                            end
                        end
                    end
                end
            end
            else
            begin
                falling = !session.atn_prev && e.line_level;
                session.atn_low_now = e.line_level;
                session.atn_prev    = e.line_level;
                if (decode_on)
                begin
                    if (falling)
                    begin
                        session.secondary              = DEV_NONE;
                        session.listening              = 1'b0;
                        session.talking                = 1'b0;
                        session.handshake_pending      = 1'b1;
                        session.handshake_just_cleared = 1'b0;
                        session.shift_bits             = '0;
                        session.bit_count              = '0;
                        session.clk_prev               = e.clk_line_high;
                    end
                    else if (!e.line_level)
                    begin
                        session.handshake_pending      = 1'b0;
                        session.handshake_just_cleared = 1'b0;
                        session.shift_bits             = '0;
                        session.bit_count              = '0;
                    end
                end
            end
            r.host_listening = session.listening;
            r.host_talking   = session.talking;
            r.device_now     = session.device;
            r.secondary_now  = session.secondary;
            r.atn_asserted   = session.atn_low_now;
            expected_results.push_back(r);
        endfunction

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        task check_result(sbcr_result_t got);
            sbcr_result_t want;
            if (expected_results.size() == 0)
            begin
                report("result transfer with nothing expected");
                return;
            end
            want = expected_results.pop_front();
            check_field("bus_action", 8'(got.bus_action), 8'(want.bus_action));
            check_field("action_device", 8'(got.action_device), 8'(want.action_device));
            check_field("action_secondary", 8'(got.action_secondary),
                        8'(want.action_secondary));
            check_field("byte_done", 8'(got.byte_done), 8'(want.byte_done));
            check_field("command_byte", got.command_byte, want.command_byte);
            check_field("host_listening", 8'(got.host_listening), 8'(want.host_listening));
            check_field("host_talking", 8'(got.host_talking), 8'(want.host_talking));
            check_field("device_now", got.device_now, want.device_now);
            check_field("secondary_now", got.secondary_now, want.secondary_now);
            check_field("atn_asserted", 8'(got.atn_asserted), 8'(want.atn_asserted));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_enable;
    logic cfg_write_data;

    sbcr_event_if  ev_ch ();
    sbcr_result_if res_ch ();

    command_session_scoreboard board;
    sbcr_event_t               seen_event;
    sbcr_result_t              seen_result;
    int                        events_sent = 0;
    int                        tx_idle_pct = 6;
    int                        rx_idle_pct = 61;
    bit                        hold_off_armed = 1'b0;

    serial_bus_command_receiver_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .event_ch         (ev_ch),
        .result_ch        (res_ch)
    );

    always #4 clk = ~clk;

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_event(input logic cmd, input logic lvl, input logic data_hi,
                              input logic clk_hi);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            ev_ch.valid <= 1'b0;
            @(negedge clk);
        end
        ev_ch.valid          <= 1'b1;
        ev_ch.command        <= cmd;
        ev_ch.line_level     <= lvl;
        ev_ch.data_line_high <= data_hi;
        ev_ch.clk_line_high  <= clk_hi;
        do
            @(posedge clk);
        while (ev_ch.ready !== 1'b1);
        @(negedge clk);
        events_sent++;
    endtask

    task automatic wait_until_drained();
        int waited = 0;
        ev_ch.valid <= 1'b0;
        while (board.expected_results.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_protocol_enable(input logic value);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        board.decode_on = value;
    endtask

    task automatic send_command_byte(input logic [7:0] b, input int bits);
        for (int i = 0; i < bits; i++)
        begin
            send_event(CMD_CLOCK, 1'b1, rand_bit(), rand_bit());
            send_event(CMD_CLOCK, 1'b0, b[i], rand_bit());
        end
    endtask

    task automatic open_attention();
        logic clk_hi;
        clk_hi = rand_bit();
        send_event(CMD_ATN, 1'b1, rand_bit(), clk_hi);
        if (clk_hi || rand_bit())
            send_event(CMD_CLOCK, 1'b0, rand_bit(), rand_bit());
        send_event(CMD_CLOCK, 1'b1, rand_bit(), rand_bit());
        send_event(CMD_CLOCK, 1'b0, rand_bit(), rand_bit());
    endtask

    function automatic logic [7:0] pick_command_byte();
        logic [7:0] top;
        case ($urandom_range(0, 2))
            0:       top = SEC_TOP_A;
            1:       top = SEC_TOP_B;
            default: top = SEC_TOP_C;
        endcase
        case ($urandom_range(0, 9))
            0, 1:    return LISTEN_GROUP | 8'($urandom_range(0, 30));
            2, 3:    return TALK_GROUP | 8'($urandom_range(0, 30));
            4:       return UNLISTEN_BYTE;
            5:       return UNTALK_BYTE;
            6, 7:    return top | 8'($urandom_range(0, 15));
            8:       return CLOSE_TOP | 8'($urandom_range(0, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random(input int target);
        int n_bytes;
        int bits;
        while (events_sent < target)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                open_attention();
                n_bytes = $urandom_range(1, 3);
                for (int k = 0; k < n_bytes; k++)
                begin
                    bits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8;
                    send_command_byte(pick_command_byte(), bits);
                    if (bits < 8)
                        break;
                end
                send_event(CMD_ATN, 1'b0, rand_bit(), rand_bit());
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_event(rand_bit(), rand_bit(), rand_bit(), rand_bit());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && ev_ch.valid && ev_ch.ready)
        begin
            seen_event.command        = ev_ch.command;
            seen_event.line_level     = ev_ch.line_level;
            seen_event.data_line_high = ev_ch.data_line_high;
            seen_event.clk_line_high  = ev_ch.clk_line_high;
            board.note_event(seen_event);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen_result.bus_action       = res_ch.bus_action;
            seen_result.action_device    = res_ch.action_device;
            seen_result.action_secondary = res_ch.action_secondary;
            seen_result.byte_done        = res_ch.byte_done;
            seen_result.command_byte     = res_ch.command_byte;
            seen_result.host_listening   = res_ch.host_listening;
            seen_result.host_talking     = res_ch.host_talking;
            seen_result.device_now       = res_ch.device_now;
            seen_result.secondary_now    = res_ch.secondary_now;
            seen_result.atn_asserted     = res_ch.atn_asserted;
            board.check_result(seen_result);
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (60) @(negedge clk);
            end
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        board                = new();
        rst_n                = 1'b0;
        cfg_write_enable     = 1'b0;
        cfg_write_data       = 1'b0;
        ev_ch.valid          = 1'b0;
        ev_ch.command        = CMD_CLOCK;
        ev_ch.line_level     = 1'b0;
        ev_ch.data_line_high = 1'b0;
        ev_ch.clk_line_high  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // decoding off: levels tracked only
        write_protocol_enable(1'b0);
        send_event(CMD_ATN, 1'b1, 1'b0, 1'b1);
        send_event(CMD_ATN, 1'b0, 1'b1, 1'b0);
        wait_until_drained();
        write_protocol_enable(1'b1);

        // clock edge with ATN released, then a full handshake with every quirk
        send_event(CMD_CLOCK, 1'b1, 1'b1, 1'b1);
        send_event(CMD_ATN, 1'b1, 1'b0, 1'b1);
        send_event(CMD_CLOCK, 1'b0, 1'b0, 1'b0);
        send_event(CMD_CLOCK, 1'b1, 1'b1, 1'b1);
        send_event(CMD_ATN, 1'b1, 1'b1, 1'b1);
        send_event(CMD_CLOCK, 1'b0, 1'b1, 1'b0);
        send_command_byte(UNLISTEN_BYTE, 8);
        send_event(CMD_ATN, 1'b0, 1'b0, 1'b0);

        run_random(350);

        wait_until_drained();
        write_protocol_enable(1'b0);
        tx_idle_pct = 61;
        rx_idle_pct = 6;
        run_random(420);

        wait_until_drained();
        write_protocol_enable(1'b1);
        run_random(650);

        wait_until_drained();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_off_armed = 1'b1;
        run_random(925);

        wait_until_drained();
        if (board.expected_results.size() != 0)
            board.report($sformatf("%0d expected results never arrived",
                                   board.expected_results.size()));
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/sbcr_pkg.sv
rtl/sbcr_if.sv
rtl/sbcr_decode.sv
rtl/sbcr_step.sv
rtl/serial_bus_command_receiver_top.sv
bench/tb_top.sv
